// ----- sv/cpfv_pkg.sv -----
// Package with the types, constants and helper functions of the CPF check-digit validator.
package cpfv_pkg;

	localparam logic [7:0] ASCII_ZERO = 8'd48;
	localparam logic [7:0] ASCII_NINE = 8'd57;
	localparam logic [7:0] DOT_CODE   = 8'd46;
	localparam logic [7:0] DASH_CODE  = 8'd45;
	localparam logic [3:0] MOD_BASE   = 4'd11;
	localparam logic [3:0] LAST_POS   = 4'd13;
	localparam logic [3:0] POS_MAX    = 4'd15;
	localparam logic [7:0] RECIP_11   = 8'd187;

	typedef enum logic [2:0] {
		KIND_DIGIT,
		KIND_DOT,
		KIND_DASH,
		KIND_CHECK1,
		KIND_CHECK2,
		KIND_NONE
	} kind_t;

	typedef struct packed {
		logic [3:0] position;
		logic [3:0] first_mod;
		logic [3:0] second_mod;
		logic       format_bad;
		logic       check_bad;
	} state_t;

	typedef struct packed {
		logic valid_res;
		logic length_error;
		logic format_error;
		logic check_error;
	} result_t;

	function automatic kind_t pos_kind(input logic [3:0] pos);
		kind_t k;
		unique case (pos)
			4'd3, 4'd7: k = KIND_DOT;
			4'd11:      k = KIND_DASH;
			4'd12:      k = KIND_CHECK1;
			4'd13:      k = KIND_CHECK2;
			4'd14, 4'd15: k = KIND_NONE;
			default:    k = KIND_DIGIT;
		endcase
		return k;
	endfunction

	function automatic logic [3:0] weight_one(input logic [3:0] pos);
		logic [3:0] w;
		unique case (pos)
			4'd0:    w = 4'd10;
			4'd1:    w = 4'd9;
			4'd2:    w = 4'd8;
			4'd4:    w = 4'd7;
			4'd5:    w = 4'd6;
			4'd6:    w = 4'd5;
			4'd8:    w = 4'd4;
			4'd9:    w = 4'd3;
			4'd10:   w = 4'd2;
			default: w = 4'd0;
		endcase
		return w;
	endfunction

	function automatic logic [3:0] weight_two(input logic [3:0] pos);
		logic [3:0] w;
		unique case (pos)
			4'd0:    w = 4'd11;
			4'd1:    w = 4'd10;
			4'd2:    w = 4'd9;
			4'd4:    w = 4'd8;
			4'd5:    w = 4'd7;
			4'd6:    w = 4'd6;
			4'd8:    w = 4'd5;
			4'd9:    w = 4'd4;
			4'd10:   w = 4'd3;
			4'd12:   w = 4'd2;
			default: w = 4'd0;
		endcase
		return w;
	endfunction

	// Remainder by 11 of a value below 110, through a reciprocal multiply.
	function automatic logic [3:0] mod11_small(input logic [6:0] t);
		logic [14:0] prod;
		logic [3:0]  q;
		logic [6:0]  qm;
		logic [6:0]  rem;
		prod = 15'(t) * 15'(RECIP_11);
		q    = prod[14:11];
		qm   = 7'(q) * 7'(MOD_BASE);
		rem  = t - qm;
		return rem[3:0];
	endfunction

	// Weighted term of one digit, reduced modulo 11.
	function automatic logic [3:0] term_mod(input logic [3:0] d, input logic [3:0] w);
		logic [7:0] p;
		p = 8'(d) * 8'(w);
		return mod11_small(p[6:0]);
	endfunction

	function automatic logic [3:0] add_mod(input logic [3:0] a, input logic [3:0] b);
		logic [4:0] s;
		s = 5'(a) + 5'(b);
		if (s >= 5'(MOD_BASE)) begin
			s = s - 5'(MOD_BASE);
		end
		return s[3:0];
	endfunction

	// Check digit for a sum given modulo 11; a remainder of zero or one gives zero.
	function automatic logic [3:0] expected_digit(input logic [3:0] sum_mod);
		logic [3:0] e;
		if (sum_mod <= 4'd1) begin
			e = 4'd0;
		end else begin
			e = MOD_BASE - sum_mod;
		end
		return e;
	endfunction

endpackage

// ----- sv/cpf_check_digit_validator_top.sv -----
// Top level of the streaming CPF check-digit validator.
//
//   channel | direction | handshake             | payload
//   input   | in        | in_valid / in_stall   | char_code, last
//   output  | out       | out_valid / out_stall | valid_res, length_error,
//           |           |                       | format_error, check_error
//
// One character is taken per cycle while the input is not stalled; the result of a
// final character is shown through the input register and the result register.
// Reset clears the valid flags of the input and result registers and the running state.
// A stall on the output holds the result; the input stalls only while a final
// character waits in the input register behind a result that is still held.
module cpf_check_digit_validator_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       valid_res,
	output logic       length_error,
	output logic       format_error,
	output logic       check_error
);

	logic              valid_s1;
	logic [7:0]        char_code_s1;
	logic              last_s1;
	logic              advance;
	cpfv_pkg::state_t  state_q;
	cpfv_pkg::state_t  state_next;
	cpfv_pkg::result_t result;

	assign in_stall = valid_s1 && last_s1 && out_valid && out_stall;
	assign advance  = valid_s1 && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_code_s1 <= char_code;
			last_s1      <= last;
		end
	end

	cpfv_step u_step (
		.state_q    (state_q),
		.char_code  (char_code_s1),
		.last       (last_s1),
		.state_next (state_next),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			valid_res    <= result.valid_res;
			length_error <= result.length_error;
			format_error <= result.format_error;
			check_error  <= result.check_error;
		end
	end

endmodule

// ----- sv/cpfv_step.sv -----
// Per-character update of the validator state and the result for a final character.
module cpfv_step (
	input  cpfv_pkg::state_t  state_q,
	input  logic [7:0]        char_code,
	input  logic              last,
	output cpfv_pkg::state_t  state_next,
	output cpfv_pkg::result_t result
);

	logic              is_digit;
	logic [7:0]        digit_full;
	logic [3:0]        digit;
	logic [3:0]        term1;
	logic [3:0]        term2;
	cpfv_pkg::kind_t   kind;
	cpfv_pkg::state_t  upd;

	assign is_digit   = (char_code >= cpfv_pkg::ASCII_ZERO) &&
		(char_code <= cpfv_pkg::ASCII_NINE);
	assign digit_full = char_code - cpfv_pkg::ASCII_ZERO;
	assign digit      = is_digit ? digit_full[3:0] : 4'd0;
	assign kind       = cpfv_pkg::pos_kind(state_q.position);
	assign term1      = cpfv_pkg::term_mod(digit, cpfv_pkg::weight_one(state_q.position));
	assign term2      = cpfv_pkg::term_mod(digit, cpfv_pkg::weight_two(state_q.position));

	always_comb begin
		upd = state_q;
		unique case (kind)
			cpfv_pkg::KIND_DIGIT: begin
				if (!is_digit) begin
					upd.format_bad = 1'b1;
				end
				upd.first_mod  = cpfv_pkg::add_mod(state_q.first_mod, term1);
				upd.second_mod = cpfv_pkg::add_mod(state_q.second_mod, term2);
			end
			cpfv_pkg::KIND_DOT: begin
				if (char_code != cpfv_pkg::DOT_CODE) begin
					upd.format_bad = 1'b1;
				end
			end
			cpfv_pkg::KIND_DASH: begin
				if (char_code != cpfv_pkg::DASH_CODE) begin
					upd.format_bad = 1'b1;
				end
			end
			cpfv_pkg::KIND_CHECK1: begin
				if (!is_digit) begin
					upd.format_bad = 1'b1;
					upd.check_bad  = 1'b1;
				end else if (digit != cpfv_pkg::expected_digit(state_q.first_mod)) begin
					upd.check_bad = 1'b1;
				end
				upd.second_mod = cpfv_pkg::add_mod(state_q.second_mod, term2);
			end
			cpfv_pkg::KIND_CHECK2: begin
				if (!is_digit) begin
					upd.format_bad = 1'b1;
					upd.check_bad  = 1'b1;
				end else if (digit != cpfv_pkg::expected_digit(state_q.second_mod)) begin
					upd.check_bad = 1'b1;
				end
			end
			cpfv_pkg::KIND_NONE: begin
			end
			default: begin
			end
		endcase
		if (state_q.position != cpfv_pkg::POS_MAX) begin
			upd.position = state_q.position + 4'd1;
		end
	end

	always_comb begin
		result.length_error = (state_q.position != cpfv_pkg::LAST_POS);
		result.check_error  = upd.check_bad || (state_q.position < cpfv_pkg::LAST_POS);
		result.format_error = upd.format_bad;
		result.valid_res    = !(result.length_error || result.check_error ||
			result.format_error);
	end

	always_comb begin
		if (last) begin
			state_next = '0;
		end else begin
			state_next = upd;
		end
	end

endmodule

// ----- sv/cpfv_checker.sv -----
// Port-level checks of the CPF check-digit validator and their binding to the top level.
module cpfv_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic last,
	input logic out_valid,
	input logic out_stall,
	input logic valid_res,
	input logic length_error,
	input logic format_error,
	input logic check_error
);

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Result withdrawn while stalled.");

	// The valid flag is set exactly when no error flag is set.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (valid_res == !(length_error || format_error || check_error)))
		else $error("Valid flag disagrees with the error flags.");

	// The input stalls only behind a held result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("Input stalled while the output is free.");

	// A new result follows a final-character transaction through the input and result registers.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && last, 2))
		else $error("Result without a final-character transaction.");

endmodule

bind cpf_check_digit_validator_top cpfv_checker u_checker (.*);
